// ===== design/nps_pkg.sv =====
package nps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIM        = 6;
    localparam int COORD_W    = 16;

    localparam int NUM_COORDS = 6;
    localparam int IO_COORD_W = 16;
    localparam int PARENT_W   = 16;
    localparam int INDEX_W    = 6;
    localparam int DIST_W     = 35;
    localparam int DIMS_W     = 3;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;

    localparam logic [DIMS_W-1:0] DIMS_MAX = DIMS_W'(DIM);
    localparam logic [DIMS_W-1:0] DIMS_MIN = DIMS_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    typedef logic [DIM-1:0][COORD_W-1:0] t_coords;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic [PARENT_W-1:0]          parent_id;
        logic signed [IO_COORD_W-1:0] coord_0;
        logic signed [IO_COORD_W-1:0] coord_1;
        logic signed [IO_COORD_W-1:0] coord_2;
        logic signed [IO_COORD_W-1:0] coord_3;
        logic signed [IO_COORD_W-1:0] coord_4;
        logic signed [IO_COORD_W-1:0] coord_5;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [INDEX_W-1:0]           nearest_index;
        logic [PARENT_W-1:0]          nearest_parent;
        logic [DIST_W-1:0]            distance_sq;
        logic signed [IO_COORD_W-1:0] near_c0;
        logic signed [IO_COORD_W-1:0] near_c1;
        logic signed [IO_COORD_W-1:0] near_c2;
        logic signed [IO_COORD_W-1:0] near_c3;
        logic signed [IO_COORD_W-1:0] near_c4;
        logic signed [IO_COORD_W-1:0] near_c5;
    } t_out;

    typedef struct packed {
        logic [PARENT_W-1:0] parent;
        t_coords             coord;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic last;
    } t_scan_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        t_entry            entry;
        logic [DIST_W-1:0] dist_sq;
    } t_best;

    function automatic t_coords in_coords(t_in d);
        logic [NUM_COORDS-1:0][IO_COORD_W-1:0] all;
        t_coords c;
        all = {d.coord_5, d.coord_4, d.coord_3, d.coord_2, d.coord_1, d.coord_0};
        c = '0;
        for (int j = 0; j < DIM; j++) begin
            c[j] = COORD_W'($signed(all[j]));
        end
        return c;
    endfunction

    function automatic t_out status_result(t_status s);
        t_out r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    function automatic t_out make_result(t_best b);
        logic [NUM_COORDS-1:0][IO_COORD_W-1:0] c;
        t_out r;
        c = '0;
        for (int j = 0; j < DIM; j++) begin
            c[j] = IO_COORD_W'(b.entry.coord[j]);
        end
        r = '0;
        r.status         = STATUS_OK;
        r.nearest_index  = INDEX_W'(b.idx);
        r.nearest_parent = b.entry.parent;
        r.distance_sq    = b.dist_sq;
        r.near_c0        = c[0];
        r.near_c1        = c[1];
        r.near_c2        = c[2];
        r.near_c3        = c[3];
        r.near_c4        = c[4];
        r.near_c5        = c[5];
        return r;
    endfunction

endpackage

// ===== design/nps_ram.sv =====
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/nps_dist.sv =====
module nps_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nps_pkg::t_scan_ctl                i_ctl,
    input  logic [nps_pkg::ADDR_W-1:0]        i_idx,
    input  nps_pkg::t_entry                   i_entry,
    input  nps_pkg::t_coords                  i_query,
    input  logic [nps_pkg::DIMS_W-1:0]        i_dims,
    output nps_pkg::t_scan_ctl                o_ctl,
    output logic [nps_pkg::ADDR_W-1:0]        o_idx,
    output nps_pkg::t_entry                   o_entry,
    output logic [nps_pkg::DIST_W-1:0]        o_dist
);

    logic signed [nps_pkg::DIFF_W-1:0]   diff [nps_pkg::DIM];
    logic signed [2*nps_pkg::DIFF_W-1:0] prod [nps_pkg::DIM];

    logic [nps_pkg::DIM-1:0][nps_pkg::SQ_W-1:0] r_sq, n_sq;
    nps_pkg::t_scan_ctl                         r_ctl1, r_ctl2;
    logic [nps_pkg::ADDR_W-1:0]                 r_idx1, r_idx2;
    nps_pkg::t_entry                            r_entry1, r_entry2;
    logic [nps_pkg::DIST_W-1:0]                 r_dist, n_dist;

    // stage 1: per-lane difference and square
    always_comb begin
        for (int j = 0; j < nps_pkg::DIM; j++) begin
            diff[j] = $signed({i_query[j][nps_pkg::COORD_W-1], i_query[j]})
                    - $signed({i_entry.coord[j][nps_pkg::COORD_W-1], i_entry.coord[j]});
            prod[j] = diff[j] * diff[j];
            n_sq[j] = (nps_pkg::DIMS_W'(j) < i_dims) ? prod[j][nps_pkg::SQ_W-1:0] : '0;
        end
    end

    // stage 2: lane sum
    always_comb begin
        n_dist = '0;
        for (int j = 0; j < nps_pkg::DIM; j++) begin
            n_dist = n_dist + nps_pkg::DIST_W'(r_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq     <= n_sq;
        r_idx1   <= i_idx;
        r_entry1 <= i_entry;
        r_dist   <= n_dist;
        r_idx2   <= r_idx1;
        r_entry2 <= r_entry1;
    end

    assign o_ctl   = r_ctl2;
    assign o_idx   = r_idx2;
    assign o_entry = r_entry2;
    assign o_dist  = r_dist;

endmodule

// ===== design/nps_best.sv =====
module nps_best (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nps_pkg::t_scan_ctl         i_ctl,
    input  logic [nps_pkg::ADDR_W-1:0] i_idx,
    input  nps_pkg::t_entry            i_entry,
    input  logic [nps_pkg::DIST_W-1:0] i_dist,
    output nps_pkg::t_best             o_best,
    output logic                       o_done
);

    nps_pkg::t_best r_best;
    logic           r_done;
    logic           take;

    // entry 0 seeds the scan and keeps ties; later entries take ties from each other
    always_comb begin
        take = i_ctl.valid
            && ((i_idx == '0)
                || (i_dist < r_best.dist_sq)
                || ((i_dist == r_best.dist_sq) && (r_best.idx != '0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid && i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best.idx     <= i_idx;
            r_best.entry   <= i_entry;
            r_best.dist_sq <= i_dist;
        end
    end

    assign o_best = r_best;
    assign o_done = r_done;

endmodule

// ===== design/nearest_point_linear_search_top.sv =====
// nearest point search over a table of up to 64 points, six Q4.12 coordinates each
//
// command channel: drive i_in and raise start; the command transfers at a clock
// edge where start is high and busy is low. kind selects start (clear table,
// write root at entry 0), add (append, or status full) or query (nearest point)
//
// result channel: one result per command, shown on o_out for exactly one cycle
// while o_done is high. the receiver cannot stall it
//
// start and add answer in the cycle after the transfer and leave busy low, so a
// new command can follow in the next cycle. a query reads the point memory one
// entry per cycle through one read port; the result follows once the last entry
// has passed the read, square, sum and best registers, and busy is high after
// the transfer until it shows. a query on an empty table answers as add does
//
// configuration: i_cfg_we writes dims_in_use from i_cfg_wdata (0 acts as 1,
// above 6 acts as 6). write it only while no command is in flight
//
// reset clears the point count and sets dims_in_use to 6; memory contents are
// left as they are and are never read before being written
module nearest_point_linear_search_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  nps_pkg::t_in               i_in,
    input  logic                       i_cfg_we,
    input  logic [nps_pkg::DIMS_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output nps_pkg::t_out              o_out
);

    nps_pkg::t_state            r_state, n_state;
    logic [nps_pkg::CNT_W-1:0]  r_count, n_count;
    logic [nps_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [nps_pkg::DIMS_W-1:0] r_dims;
    nps_pkg::t_coords           r_query, n_query;
    nps_pkg::t_scan_ctl         r_rd_ctl, n_rd_ctl;
    logic [nps_pkg::ADDR_W-1:0] r_rd_idx, n_rd_idx;
    nps_pkg::t_out              r_out, n_out;
    logic                       r_done, n_done;

    logic                       accept;
    logic                       scan_last;
    logic [nps_pkg::DIMS_W-1:0] dims_eff;

    logic                       ram_we;
    logic [nps_pkg::ADDR_W-1:0] ram_waddr;
    nps_pkg::t_entry            ram_wdata;
    logic                       ram_re;
    logic [nps_pkg::ADDR_W-1:0] ram_raddr;
    nps_pkg::t_entry            ram_rdata;

    nps_pkg::t_scan_ctl         dist_ctl;
    logic [nps_pkg::ADDR_W-1:0] dist_idx;
    nps_pkg::t_entry            dist_entry;
    logic [nps_pkg::DIST_W-1:0] dist_val;
    nps_pkg::t_best             best;
    logic                       best_done;

    assign busy      = (r_state != nps_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign scan_last = (nps_pkg::CNT_W'(r_addr) == (r_count - nps_pkg::CNT_W'(1)));

    always_comb begin
        if (r_dims < nps_pkg::DIMS_MIN) begin
            dims_eff = nps_pkg::DIMS_MIN;
        end else if (r_dims > nps_pkg::DIMS_MAX) begin
            dims_eff = nps_pkg::DIMS_MAX;
        end else begin
            dims_eff = r_dims;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nps_pkg::ST_IDLE: begin
                if (accept && (i_in.kind == nps_pkg::KIND_QUERY) && (r_count != '0)) begin
                    n_state = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = nps_pkg::ST_WAIT;
                end
            end
            nps_pkg::ST_WAIT: begin
                if (best_done) begin
                    n_state = nps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_addr    = r_addr;
        n_query   = r_query;
        n_rd_ctl  = '0;
        n_rd_idx  = r_rd_idx;
        n_out     = r_out;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata.parent = i_in.parent_id;
        ram_wdata.coord  = nps_pkg::in_coords(i_in);
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        case (r_state)
            nps_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in.kind)
                        nps_pkg::KIND_START: begin
                            ram_we  = 1'b1;
                            n_count = nps_pkg::CNT_W'(1);
                            n_out   = nps_pkg::status_result(nps_pkg::STATUS_OK);
                            n_done  = 1'b1;
                        end
                        nps_pkg::KIND_ADD: begin
                            if (r_count >= nps_pkg::CNT_W'(nps_pkg::MAX_POINTS)) begin
                                n_out = nps_pkg::status_result(nps_pkg::STATUS_FULL);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[nps_pkg::ADDR_W-1:0];
                                n_count   = r_count + nps_pkg::CNT_W'(1);
                                n_out     = nps_pkg::status_result(nps_pkg::STATUS_OK);
                            end
                            n_done = 1'b1;
                        end
                        nps_pkg::KIND_QUERY: begin
                            if (r_count == '0) begin
                                n_out  = nps_pkg::status_result(nps_pkg::STATUS_EMPTY);
                                n_done = 1'b1;
                            end else begin
                                n_query = nps_pkg::in_coords(i_in);
                                n_addr  = '0;
                            end
                        end
                        default: begin
                            n_out  = nps_pkg::status_result(nps_pkg::STATUS_OK);
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            nps_pkg::ST_SCAN: begin
                ram_re         = 1'b1;
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.last  = scan_last;
                n_rd_idx       = r_addr;
                n_addr         = r_addr + nps_pkg::ADDR_W'(1);
            end
            nps_pkg::ST_WAIT: begin
                if (best_done) begin
                    n_out  = nps_pkg::make_result(best);
                    n_done = 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nps_pkg::ST_IDLE;
            r_count  <= '0;
            r_dims   <= nps_pkg::DIMS_MAX;
            r_rd_ctl <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_ctl <= n_rd_ctl;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_query  <= n_query;
        r_rd_idx <= n_rd_idx;
        r_out    <= n_out;
    end

    nps_ram #(
        .WIDTH ($bits(nps_pkg::t_entry)),
        .DEPTH (nps_pkg::MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_idx   (r_rd_idx),
        .i_entry (ram_rdata),
        .i_query (r_query),
        .i_dims  (dims_eff),
        .o_ctl   (dist_ctl),
        .o_idx   (dist_idx),
        .o_entry (dist_entry),
        .o_dist  (dist_val)
    );

    nps_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dist_ctl),
        .i_idx   (dist_idx),
        .i_entry (dist_entry),
        .i_dist  (dist_val),
        .o_best  (best),
        .o_done  (best_done)
    );

    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_no_result_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::ST_SCAN) |-> !o_done)
        else $error("result strobe during scan");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nps_pkg::CNT_W'(nps_pkg::MAX_POINTS))
        else $error("point count above table size");

    a_scan_addr_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::ST_SCAN) |-> (nps_pkg::CNT_W'(r_addr) < r_count))
        else $error("scan reads an unwritten entry");

    a_best_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        best_done |-> (r_state == nps_pkg::ST_WAIT))
        else $error("scan finished outside wait state");
`endif

endmodule
